@@ src/permission_mask_table_defines.svh @@
// Assertion macros shared by the permission mask table modules.
`ifndef PERMISSION_MASK_TABLE_DEFINES_SVH
`define PERMISSION_MASK_TABLE_DEFINES_SVH

// Check that a property holds at every clock edge outside reset.
`define PMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("permission mask table: assertion failed");

// Check that a condition is followed by another in the next cycle.
`define PMT_ASSERT_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error("permission mask table: sequence check failed");

`endif

@@ src/pmt_pkg.sv @@
// Types and codes shared by the permission mask table modules.
package pmt_pkg;

  localparam int unsigned UserW = 32;
  localparam int unsigned MaskW = 64;

  typedef enum logic [1:0] {
    OP_GRANT  = 2'd0,
    OP_REVOKE = 2'd1,
    OP_CHECK  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MERGE,
    ACT_ALLOC,
    ACT_FULL,
    ACT_REVOKE,
    ACT_CHECK
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [UserW-1:0] user;
    logic [MaskW-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    act_e act;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       free;
  } stat_t;

endpackage

@@ src/pmt_ctrl.sv @@
// Sequencer for the permission mask table: request intake, table scan, update, response.
`include "permission_mask_table_defines.svh"

module pmt_ctrl
  import pmt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IDX_W   = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output logic             done_o,
  output cmd_t             cmd_o,
  output logic [IDX_W-1:0] scan_idx_o,
  input  stat_t            stat_i
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ENTRIES - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == LastIdx) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESP;
      ST_RESP:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (state_q == ST_IDLE) begin
      idx_d = '0;
    end else if (state_q == ST_SCAN && idx_q != LastIdx) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_comb begin
    cmd_o.load    = 1'b0;
    cmd_o.scan_en = 1'b0;
    cmd_o.act     = ACT_NONE;
    busy_o        = 1'b1;
    done_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SCAN: cmd_o.scan_en = 1'b1;
      ST_DRAIN: ;
      ST_UPDATE: begin
        priority if (stat_i.op == OP_GRANT) begin
          if (stat_i.hit)       cmd_o.act = ACT_MERGE;
          else if (stat_i.free) cmd_o.act = ACT_ALLOC;
          else                  cmd_o.act = ACT_FULL;
        end else if (stat_i.op == OP_REVOKE) begin
          cmd_o.act = stat_i.hit ? ACT_REVOKE : ACT_NONE;
        end else if (stat_i.op == OP_CHECK) begin
          cmd_o.act = ACT_CHECK;
        end else begin
          cmd_o.act = ACT_NONE;
        end
      end
      ST_RESP: done_o = 1'b1;
      default: ;
    endcase
  end

  assign scan_idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `PMT_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `PMT_ASSERT_NEXT(a_update_then_done, state_q == ST_UPDATE, done_o)
  `PMT_ASSERT(a_scan_in_range, !cmd_o.scan_en || idx_q <= LastIdx)

endmodule

@@ src/pmt_datapath.sv @@
// Entry storage, scan compare and update logic of the permission mask table.
`include "permission_mask_table_defines.svh"

module pmt_datapath
  import pmt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IDX_W   = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       op_i,
  input  logic [UserW-1:0] user_id_i,
  input  logic [MaskW-1:0] access_mask_i,
  input  cmd_t             cmd_i,
  input  logic [IDX_W-1:0] scan_idx_i,
  output stat_t            stat_o,
  output logic             status_o,
  output logic             allowed_o
);

  entry_t           mem_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;

  logic [1:0]       op_q;
  logic [UserW-1:0] user_q;
  logic [MaskW-1:0] mask_q;

  entry_t           rd_data_q;
  logic             cmp_valid_q;
  logic [IDX_W-1:0] cmp_idx_q;

  logic             hit_q, free_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  logic [MaskW-1:0] hit_mask_q;

  logic             status_q, allowed_q;

  logic             cmp_hit, cmp_free;
  logic [MaskW-1:0] merge_mask, rev_mask;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;
  logic             check_ok;

  assign cmp_hit  = cmp_valid_q && valid_q[cmp_idx_q] && (rd_data_q.user == user_q);
  assign cmp_free = cmp_valid_q && !valid_q[cmp_idx_q];

  assign merge_mask = hit_mask_q | mask_q;
  assign rev_mask   = hit_mask_q & ~mask_q;
  assign check_ok   = hit_q && ((hit_mask_q & mask_q) == mask_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = hit_idx_q;
    wr_data = '{user: user_q, mask: merge_mask};
    unique case (cmd_i.act)
      ACT_MERGE: wr_en = 1'b1;
      ACT_ALLOC: begin
        wr_en   = 1'b1;
        wr_idx  = free_idx_q;
        wr_data = '{user: user_q, mask: mask_q};
      end
      ACT_REVOKE: begin
        wr_en = 1'b1;
        // clear the user field too when the entry is freed
        wr_data = '{user: (rev_mask == '0) ? '0 : user_q, mask: rev_mask};
      end
      ACT_NONE, ACT_FULL, ACT_CHECK: ;
      default: ;
    endcase
  end

  // Entry memory: one read port for the scan, one write port for the update.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (cmd_i.scan_en) begin
      rd_data_q <= mem_q[scan_idx_i];
    end
  end

  // Request and match payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      user_q <= user_id_i;
      mask_q <= access_mask_i;
    end
    cmp_idx_q <= scan_idx_i;
    if (cmp_hit) begin
      hit_idx_q  <= cmp_idx_q;
      hit_mask_q <= rd_data_q.mask;
    end
    if (cmp_free && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cmp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      status_q    <= 1'b0;
      allowed_q   <= 1'b0;
    end else begin
      cmp_valid_q <= cmd_i.scan_en;
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmp_hit) hit_q <= 1'b1;
        if (cmp_free) free_q <= 1'b1;
      end
      if (cmd_i.act == ACT_ALLOC) begin
        valid_q[free_idx_q] <= 1'b1;
      end else if (cmd_i.act == ACT_REVOKE && rev_mask == '0) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
      if (cmd_i.act != ACT_NONE || cmd_i.load) begin
        status_q  <= (cmd_i.act == ACT_FULL);
        allowed_q <= (cmd_i.act == ACT_CHECK) && check_ok;
      end
    end
  end

  assign stat_o.op   = op_q;
  assign stat_o.hit  = hit_q;
  assign stat_o.free = free_q;
  assign status_o    = status_q;
  assign allowed_o   = allowed_q;

  `PMT_ASSERT(a_alloc_needs_free, cmd_i.act != ACT_ALLOC || (free_q && !hit_q))
  `PMT_ASSERT(a_no_read_on_write, !(wr_en && cmd_i.scan_en))
  `PMT_ASSERT_NEXT(a_alloc_sets_valid, cmd_i.act == ACT_ALLOC, valid_q[$past(free_idx_q)])

endmodule

@@ src/permission_mask_table.sv @@
// Top level of the permission mask table.
//
// Holds up to ENTRIES (user id, 64-bit permission mask) pairs. A request is
// taken at a rising edge with start_i high and busy_o low; op_i selects grant,
// revoke or check for user_id_i with access_mask_i. A grant to a new user
// takes the lowest free entry, or reports status_o = 1 if none is free.
// A revoke that leaves the mask zero frees the entry. A check sets allowed_o
// when the user is present and holds every requested bit.
// Each request scans the entry memory one entry per cycle over its single
// read port, then drains the last compare in ST_DRAIN and updates the entry
// in ST_UPDATE. The result appears in ST_RESP with done_o high for exactly
// one cycle; a new request is taken only after that, once the sequencer is
// back in ST_IDLE and busy_o is low, so requests never overlap.
// The receiver cannot stall: results must be taken in the done_o cycle.
// Reset clears all entry valid bits at once; the table is empty right after
// reset and a request may be issued in the first cycle.
module permission_mask_table
  import pmt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       op_i,
  input  logic [UserW-1:0] user_id_i,
  input  logic [MaskW-1:0] access_mask_i,
  output logic             done_o,
  output logic             status_o,
  output logic             allowed_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cmd_t            cmd;
  stat_t           stat;
  logic [IdxW-1:0] scan_idx;

  pmt_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .cmd_o      (cmd),
    .scan_idx_o (scan_idx),
    .stat_i     (stat)
  );

  pmt_datapath #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IdxW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_i),
    .user_id_i     (user_id_i),
    .access_mask_i (access_mask_i),
    .cmd_i         (cmd),
    .scan_idx_i    (scan_idx),
    .stat_o        (stat),
    .status_o      (status_o),
    .allowed_o     (allowed_o)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the permission mask table: directed rows, then random requests.
`timescale 1ns / 100ps

module tb_top;
  import pmt_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned NumRows = 24;
  localparam int unsigned NumRandom = 1900;
  localparam int unsigned PoolSize = 24;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [MaskW-1:0] AllOnes = {MaskW{1'b1}};

  typedef struct packed {
    logic status;
    logic allowed;
  } verdict_t;

  // One directed row; reps issues the same request for consecutive user ids.
  typedef struct packed {
    logic [1:0]       op;
    logic [UserW-1:0] user;
    logic [MaskW-1:0] mask;
    logic [4:0]       reps;
    logic             typed;
    logic             status;
    logic             allowed;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [1:0]       op_i;
  logic [UserW-1:0] user_id_i;
  logic [MaskW-1:0] access_mask_i;
  logic             done_o;
  logic             status_o;
  logic             allowed_o;

  // Mirror of the entry store
  logic             acl_valid [Depth];
  logic [UserW-1:0] acl_user  [Depth];
  logic [MaskW-1:0] acl_mask  [Depth];

  verdict_t         expected_verdicts [$];
  logic [UserW-1:0] id_pool [PoolSize];
  int               err_cnt;
  int               burst_left;

  dir_row_t dir_rows [NumRows] = '{
    '{OP_CHECK,  32'h0,         64'h0,                  5'd1,  1'b1, 1'b0, 1'b0},
    '{OP_REVOKE, 32'hFFFF_FFFF, AllOnes,                5'd1,  1'b1, 1'b0, 1'b0},
    '{OP_GRANT,  32'h0,         64'h0,                  5'd1,  1'b1, 1'b0, 1'b0},
    '{OP_CHECK,  32'h0,         64'h0,                  5'd1,  1'b1, 1'b0, 1'b1},
    '{OP_CHECK,  32'h0,         64'h1,                  5'd1,  1'b1, 1'b0, 1'b0},
    '{OP_GRANT,  32'h0,         64'hF0,                 5'd1,  1'b0, 1'b0, 1'b0},
    '{OP_CHECK,  32'h0,         64'hF0,                 5'd1,  1'b0, 1'b0, 1'b0},
    '{OP_GRANT,  32'hFFFF_FFFF, AllOnes,                5'd1,  1'b1, 1'b0, 1'b0},
    '{OP_CHECK,  32'hFFFF_FFFF, AllOnes,                5'd1,  1'b1, 1'b0, 1'b1},
    '{OP_REVOKE, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 5'd1, 1'b0, 1'b0, 1'b0},
    '{OP_CHECK,  32'hFFFF_FFFF, AllOnes,                5'd1,  1'b0, 1'b0, 1'b0},
    '{OP_CHECK,  32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 5'd1, 1'b0, 1'b0, 1'b0},
    '{OP_REVOKE, 32'hFFFF_FFFF, AllOnes,                5'd1,  1'b1, 1'b0, 1'b0},
    '{OP_CHECK,  32'hFFFF_FFFF, 64'h0,                  5'd1,  1'b1, 1'b0, 1'b0},
    '{OpUnused,  32'h0,         AllOnes,                5'd1,  1'b1, 1'b0, 1'b0},
    '{OP_CHECK,  32'h0,         64'hF0,                 5'd1,  1'b0, 1'b0, 1'b0},
    // fill the remaining entries, then hit the full table
    '{OP_GRANT,  32'd100,       64'hAAAA_AAAA_AAAA_AAAA, 5'd15, 1'b1, 1'b0, 1'b0},
    '{OP_GRANT,  32'd200,       64'h1,                  5'd1,  1'b1, 1'b1, 1'b0},
    '{OP_CHECK,  32'd200,       64'h0,                  5'd1,  1'b1, 1'b0, 1'b0},
    '{OP_GRANT,  32'h0,         64'hFFFF_0000_0000_0000, 5'd1, 1'b0, 1'b0, 1'b0},
    '{OP_REVOKE, 32'd105,       AllOnes,                5'd1,  1'b0, 1'b0, 1'b0},
    '{OP_GRANT,  32'd200,       64'h5555_5555_5555_5555, 5'd1, 1'b0, 1'b0, 1'b0},
    '{OP_CHECK,  32'd200,       64'h5555_5555_5555_5555, 5'd1, 1'b0, 1'b0, 1'b0},
    '{OP_GRANT,  32'd201,       64'h1,                  5'd1,  1'b1, 1'b1, 1'b0}
  };

  permission_mask_table #(
    .ENTRIES(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .user_id_i    (user_id_i),
    .access_mask_i(access_mask_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .allowed_o    (allowed_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [MaskW-1:0] rand_mask();
    return {$urandom(), $urandom()};
  endfunction

  // Mask currently held by a user, zero if absent.
  function automatic logic [MaskW-1:0] held_mask(logic [UserW-1:0] uid);
    logic [MaskW-1:0] m;
    m = '0;
    for (int k = 0; k < Depth; k++) begin
      if (acl_valid[k] && acl_user[k] == uid) m = acl_mask[k];
    end
    return m;
  endfunction

  // Apply one request to the mirrored table and return its verdict.
  function automatic verdict_t apply_request(logic [1:0] op, logic [UserW-1:0] uid,
                                             logic [MaskW-1:0] m);
    verdict_t v;
    int hit;
    int fr;
    v = '0;
    hit = -1;
    fr = -1;
    for (int k = 0; k < Depth; k++) begin
      if (hit < 0 && acl_valid[k] && acl_user[k] == uid) hit = k;
      if (fr < 0 && !acl_valid[k]) fr = k;
    end
    case (op)
      OP_GRANT: begin
        if (hit >= 0) begin
          acl_mask[hit] = acl_mask[hit] | m;
        end else if (fr >= 0) begin
          acl_valid[fr] = 1'b1;
          acl_user[fr] = uid;
          acl_mask[fr] = m;
        end else begin
          v.status = 1'b1;
        end
      end
      OP_REVOKE: begin
        if (hit >= 0) begin
          acl_mask[hit] = acl_mask[hit] & ~m;
          if (acl_mask[hit] == '0) begin
            acl_valid[hit] = 1'b0;
            acl_user[hit] = '0;
          end
        end
      end
      OP_CHECK: begin
        if (hit >= 0) v.allowed = ((acl_mask[hit] & m) == m);
      end
      default: ;
    endcase
    return v;
  endfunction

  // Drive one request, hold it until taken, then queue its verdict.
  task automatic issue_request(input logic [1:0] op, input logic [UserW-1:0] uid,
                               input logic [MaskW-1:0] m, input logic typed,
                               input verdict_t typed_v);
    verdict_t v;
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 40);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    user_id_i <= uid;
    access_mask_i <= m;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    v = apply_request(op, uid, m);
    expected_verdicts.push_back(typed ? typed_v : v);
    @(negedge clk_i);
  endtask

  // Draw a random request; bias users and masks so entries hit, fill and free.
  task automatic pick_request(input int idx, output logic [1:0] op,
                              output logic [UserW-1:0] uid, output logic [MaskW-1:0] m);
    int sel;
    int kind;
    int pool_n;
    int v;
    pool_n = ((idx / 150) % 2) ? PoolSize : 10;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      uid = $urandom();
    end else if (sel < 4) begin
      v = $urandom_range(0, 15);
      uid = (v == 15) ? 32'd200 : 32'd100 + v;
    end else begin
      uid = id_pool[$urandom_range(0, pool_n - 1)];
    end
    sel = $urandom_range(0, 99);
    if (sel < 40) op = OP_GRANT;
    else if (sel < 65) op = OP_REVOKE;
    else if (sel < 95) op = OP_CHECK;
    else op = OpUnused;
    kind = $urandom_range(0, 7);
    case (kind)
      0: m = '0;
      1: m = AllOnes;
      2: m = 64'h1 << $urandom_range(0, 63);
      3, 4: m = rand_mask();
      5: m = rand_mask() & rand_mask() & rand_mask();
      default: begin
        if (op == OP_CHECK) m = held_mask(uid) & rand_mask();
        else if (op == OP_REVOKE) m = (kind == 6) ? held_mask(uid) : held_mask(uid) & rand_mask();
        else m = rand_mask() & rand_mask();
      end
    endcase
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && done_o) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with no request pending: status %0b allowed %0b", status_o, allowed_o);
        err_cnt++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (status_o !== exp_v.status) begin
          $error("status: expected %0b, got %0b", exp_v.status, status_o);
          err_cnt++;
        end
        if (allowed_o !== exp_v.allowed) begin
          $error("allowed: expected %0b, got %0b", exp_v.allowed, allowed_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    logic [1:0]       op;
    logic [UserW-1:0] uid;
    logic [MaskW-1:0] m;
    verdict_t         tv;
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = OP_GRANT;
    user_id_i = '0;
    access_mask_i = '0;
    err_cnt = 0;
    burst_left = 0;
    for (int k = 0; k < Depth; k++) begin
      acl_valid[k] = 1'b0;
      acl_user[k] = '0;
      acl_mask[k] = '0;
    end
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < PoolSize; k++) id_pool[k] = $urandom();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      tv.status = dir_rows[r].status;
      tv.allowed = dir_rows[r].allowed;
      for (int i = 0; i < dir_rows[r].reps; i++) begin
        issue_request(dir_rows[r].op, dir_rows[r].user + i, dir_rows[r].mask,
                      dir_rows[r].typed, tv);
      end
    end

    tv = '0;
    for (int n = 0; n < NumRandom; n++) begin
      pick_request(n, op, uid, m);
      issue_request(op, uid, m, 1'b0, tv);
    end
    start_i <= 1'b0;

    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
